>>> src/ptom_pkg.sv
package ptom_pkg;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_ADDED     = 3'd1,
    KIND_ZERO_QTY  = 3'd2,
    KIND_REJECT    = 3'd3,
    KIND_CANCELLED = 3'd4,
    KIND_NOT_FOUND = 3'd5
  } kind_e;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;

  // At most this many trades per item, so that the closing result always fits.
  localparam logic [5:0] MAX_TRADES = 6'd63;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_FIND_END,
    ST_DECIDE,
    ST_MATCH,
    ST_MATCH_END,
    ST_CHECK,
    ST_WB_BID,
    ST_WB_ASK
  } state_e;

  // Fields of a resting order that never change while it rests.
  typedef struct packed {
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [47:0] stamp;
    logic [31:0] arrival;
  } info_t;

  // Write side of the order store.
  typedef struct packed {
    logic        info_we;
    logic        qty_we;
    logic        set_valid;
    logic        clr_valid;
    info_t       info;
    logic [31:0] qty;
  } store_wr_t;

endpackage

>>> src/price_time_order_matcher.sv
// Price-time priority order book matcher.
// The input channel (in_valid_i / in_ready_o) carries one item: an add of a
// limit order or a cancel by id. The output channel (out_valid_o /
// out_ready_i) returns the results of that item: zero or more trade results
// followed by a closing result with last_o set. Every item ends in exactly one
// result with last_o high.
// Resting orders live in a single-port-read order store (one memory for the
// fixed order fields, one for the open quantity) with valid flags in flops.
// An item first sweeps the store for its id and a free slot, then decides.
// An add that rests then runs passes that each sweep for the best bid and
// best ask, and each trade adds a write-back of the bid and then of the ask.
// Only one item is in flight at a time; in_ready_o is high while the block is
// idle. Results sit in an output register; when the receiver stalls, the
// block waits with that result held and resumes once it is taken.
// Reset empties the book and clears the arrival counter; no clearing pass is
// needed since every slot carries a valid flag.
module price_time_order_matcher #(
  parameter int ORDER_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] order_id_i,
  input  logic        side_i,
  input  logic [31:0] price_i,
  input  logic [31:0] quantity_i,
  input  logic [47:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [31:0] bid_order_id_o,
  output logic [31:0] ask_order_id_o,
  output logic [31:0] trade_quantity_o,
  output logic [31:0] trade_price_o,
  output logic        full_fill_o,
  output logic [31:0] subject_id_o,
  output logic [31:0] remaining_quantity_o,
  output logic        last_o
);

  localparam int IDX_W = $clog2(ORDER_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER_SLOTS - 1);

  ptom_pkg::state_e state_q, state_d;

  // Latched item.
  logic        cmd_q, side_q;
  logic [31:0] id_q, price_q, qty_q;
  logic [47:0] stamp_q;

  logic [31:0]      arr_cnt_q;
  logic [IDX_W-1:0] scan_idx_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  // Lookup results of the first sweep.
  logic             found_q, free_vld_q;
  logic [IDX_W-1:0] found_idx_q, free_idx_q;

  // Best bid and best ask of a matching pass.
  logic             bid_vld_q, ask_vld_q;
  logic [IDX_W-1:0] bid_idx_q, ask_idx_q;
  logic [31:0]      bid_price_q, ask_price_q, bid_age_q, ask_age_q;
  logic [31:0]      bid_qty_q, ask_qty_q, bid_id_q, ask_id_q;
  logic [47:0]      bid_stamp_q, ask_stamp_q;

  logic [5:0]  trades_q;
  logic [31:0] rem_q;

  // Store interface.
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  ptom_pkg::info_t     rd_info;
  logic [31:0]         rd_qty;
  logic                rd_valid;
  ptom_pkg::store_wr_t wr;

  // Output register.
  logic        out_valid_q, out_load, out_free;
  logic [2:0]  kind_d;
  logic [31:0] bid_d, ask_d, tq_d, tp_d, subj_d, rem_d;
  logic        full_d, last_d;

  logic        in_fire, crossed;
  logic [31:0] trade_qty, trade_px, bid_left, ask_left, rd_age;

  ptom_store #(
    .ORDER_SLOTS(ORDER_SLOTS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_info_o (rd_info),
    .rd_qty_o  (rd_qty),
    .rd_valid_o(rd_valid),
    .wr_addr_i (wr_addr),
    .wr_i      (wr)
  );

  assign in_ready_o = (state_q == ptom_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // The book is crossed while the best bid reaches the best ask and the item has not yet hit the trade limit.
  assign crossed = bid_vld_q && ask_vld_q && (bid_price_q >= ask_price_q)
                   && (trades_q != ptom_pkg::MAX_TRADES);
  assign trade_qty = (bid_qty_q < ask_qty_q) ? bid_qty_q : ask_qty_q;
  // The earlier order sets the price; equal stamps take the ask price.
  assign trade_px  = (bid_stamp_q < ask_stamp_q) ? bid_price_q : ask_price_q;
  assign bid_left  = bid_qty_q - trade_qty;
  assign ask_left  = ask_qty_q - trade_qty;
  assign rd_age    = arr_cnt_q - rd_info.arrival;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptom_pkg::ST_IDLE: begin
        if (in_fire) state_d = ptom_pkg::ST_FIND;
      end
      ptom_pkg::ST_FIND: begin
        if (scan_idx_q == LAST_IDX) state_d = ptom_pkg::ST_FIND_END;
      end
      ptom_pkg::ST_FIND_END: state_d = ptom_pkg::ST_DECIDE;
      ptom_pkg::ST_DECIDE: begin
        if (cmd_q == ptom_pkg::CMD_ADD && qty_q != '0 && !found_q && free_vld_q) begin
          state_d = ptom_pkg::ST_MATCH;
        end else if (out_free) begin
          state_d = ptom_pkg::ST_IDLE;
        end
      end
      ptom_pkg::ST_MATCH: begin
        if (scan_idx_q == LAST_IDX) state_d = ptom_pkg::ST_MATCH_END;
      end
      ptom_pkg::ST_MATCH_END: state_d = ptom_pkg::ST_CHECK;
      ptom_pkg::ST_CHECK: begin
        if (out_free) begin
          state_d = crossed ? ptom_pkg::ST_WB_BID : ptom_pkg::ST_IDLE;
        end
      end
      ptom_pkg::ST_WB_BID: state_d = ptom_pkg::ST_WB_ASK;
      ptom_pkg::ST_WB_ASK: state_d = ptom_pkg::ST_MATCH;
      default: state_d = ptom_pkg::ST_IDLE;
    endcase
  end

  // Store accesses and results.
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = scan_idx_q;
    wr_addr      = free_idx_q;
    wr           = '0;
    wr.info.id      = id_q;
    wr.info.side    = side_q;
    wr.info.price   = price_q;
    wr.info.stamp   = stamp_q;
    wr.info.arrival = arr_cnt_q;
    wr.qty       = qty_q;
    out_load     = 1'b0;
    kind_d       = ptom_pkg::KIND_ADDED;
    bid_d        = '0;
    ask_d        = '0;
    tq_d         = '0;
    tp_d         = '0;
    full_d       = 1'b0;
    subj_d       = id_q;
    rem_d        = '0;
    last_d       = 1'b1;
    unique case (state_q)
      ptom_pkg::ST_FIND, ptom_pkg::ST_MATCH: rd_en = 1'b1;
      ptom_pkg::ST_DECIDE: begin
        if (cmd_q == ptom_pkg::CMD_CANCEL) begin
          out_load      = out_free;
          kind_d        = found_q ? ptom_pkg::KIND_CANCELLED : ptom_pkg::KIND_NOT_FOUND;
          wr_addr       = found_idx_q;
          wr.clr_valid  = out_free && found_q;
        end else if (qty_q == '0) begin
          out_load = out_free;
          kind_d   = ptom_pkg::KIND_ZERO_QTY;
        end else if (found_q || !free_vld_q) begin
          out_load = out_free;
          kind_d   = ptom_pkg::KIND_REJECT;
        end else begin
          wr.info_we   = 1'b1;
          wr.qty_we    = 1'b1;
          wr.set_valid = 1'b1;
        end
      end
      ptom_pkg::ST_CHECK: begin
        out_load = out_free;
        if (crossed) begin
          kind_d = ptom_pkg::KIND_TRADE;
          bid_d  = bid_id_q;
          ask_d  = ask_id_q;
          tq_d   = trade_qty;
          tp_d   = trade_px;
          full_d = (bid_left == '0) && (ask_left == '0);
          subj_d = '0;
          last_d = 1'b0;
        end else begin
          rem_d = rem_q;
        end
      end
      ptom_pkg::ST_WB_BID: begin
        wr_addr      = bid_idx_q;
        wr.qty_we    = 1'b1;
        wr.qty       = bid_left;
        wr.clr_valid = (bid_left == '0);
      end
      ptom_pkg::ST_WB_ASK: begin
        wr_addr      = ask_idx_q;
        wr.qty_we    = 1'b1;
        wr.qty       = ask_left;
        wr.clr_valid = (ask_left == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptom_pkg::ST_IDLE;
      arr_cnt_q   <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      free_vld_q  <= 1'b0;
      bid_vld_q   <= 1'b0;
      ask_vld_q   <= 1'b0;
      trades_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (rd_en) begin
        scan_idx_q <= (scan_idx_q == LAST_IDX) ? '0 : scan_idx_q + 1'b1;
      end
      if (in_fire) begin
        found_q    <= 1'b0;
        free_vld_q <= 1'b0;
      end
      if (rd_vld_q && state_q != ptom_pkg::ST_MATCH && state_q != ptom_pkg::ST_MATCH_END) begin
        if (rd_valid && !found_q && rd_info.id == id_q) found_q <= 1'b1;
        if (!rd_valid && !free_vld_q) free_vld_q <= 1'b1;
      end
      if (state_q == ptom_pkg::ST_DECIDE && state_d == ptom_pkg::ST_MATCH) begin
        arr_cnt_q <= arr_cnt_q + 1'b1;
        trades_q  <= '0;
      end
      if (state_d == ptom_pkg::ST_MATCH && state_q != ptom_pkg::ST_MATCH) begin
        bid_vld_q <= 1'b0;
        ask_vld_q <= 1'b0;
      end
      if (state_q == ptom_pkg::ST_WB_ASK) trades_q <= trades_q + 1'b1;
      if (rd_vld_q && rd_valid &&
          (state_q == ptom_pkg::ST_MATCH || state_q == ptom_pkg::ST_MATCH_END)) begin
        if (rd_info.side == ptom_pkg::SIDE_BUY) begin
          if (!bid_vld_q || rd_info.price > bid_price_q ||
              (rd_info.price == bid_price_q && rd_age > bid_age_q)) begin
            bid_vld_q <= 1'b1;
          end
        end else begin
          if (!ask_vld_q || rd_info.price < ask_price_q ||
              (rd_info.price == ask_price_q && rd_age > ask_age_q)) begin
            ask_vld_q <= 1'b1;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= cmd_i;
      id_q    <= order_id_i;
      side_q  <= side_i;
      price_q <= price_i;
      qty_q   <= quantity_i;
      stamp_q <= timestamp_i;
    end
    if (rd_vld_q && state_q != ptom_pkg::ST_MATCH && state_q != ptom_pkg::ST_MATCH_END) begin
      if (rd_valid && !found_q && rd_info.id == id_q) found_idx_q <= rd_idx_q;
      if (!rd_valid && !free_vld_q) free_idx_q <= rd_idx_q;
    end
    rd_idx_q <= rd_addr;
    if (state_q == ptom_pkg::ST_DECIDE) rem_q <= qty_q;
    if (state_q == ptom_pkg::ST_WB_BID && bid_idx_q == free_idx_q) rem_q <= bid_left;
    if (state_q == ptom_pkg::ST_WB_ASK && ask_idx_q == free_idx_q) rem_q <= ask_left;
    if (rd_vld_q && rd_valid &&
        (state_q == ptom_pkg::ST_MATCH || state_q == ptom_pkg::ST_MATCH_END)) begin
      if (rd_info.side == ptom_pkg::SIDE_BUY) begin
        if (!bid_vld_q || rd_info.price > bid_price_q ||
            (rd_info.price == bid_price_q && rd_age > bid_age_q)) begin
          bid_idx_q   <= rd_idx_q;
          bid_price_q <= rd_info.price;
          bid_age_q   <= rd_age;
          bid_qty_q   <= rd_qty;
          bid_id_q    <= rd_info.id;
          bid_stamp_q <= rd_info.stamp;
        end
      end else begin
        if (!ask_vld_q || rd_info.price < ask_price_q ||
            (rd_info.price == ask_price_q && rd_age > ask_age_q)) begin
          ask_idx_q   <= rd_idx_q;
          ask_price_q <= rd_info.price;
          ask_age_q   <= rd_age;
          ask_qty_q   <= rd_qty;
          ask_id_q    <= rd_info.id;
          ask_stamp_q <= rd_info.stamp;
        end
      end
    end
    if (out_load) begin
      kind_o               <= kind_d;
      bid_order_id_o       <= bid_d;
      ask_order_id_o       <= ask_d;
      trade_quantity_o     <= tq_d;
      trade_price_o        <= tp_d;
      full_fill_o          <= full_d;
      subject_id_o         <= subj_d;
      remaining_quantity_o <= rem_d;
      last_o               <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/ptom_store.sv
module ptom_store #(
  parameter int ORDER_SLOTS = 64,
  parameter int IDX_W       = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output ptom_pkg::info_t      rd_info_o,
  output logic [31:0]          rd_qty_o,
  output logic                 rd_valid_o,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  ptom_pkg::store_wr_t  wr_i
);

  ptom_pkg::info_t        info_mem [ORDER_SLOTS];
  logic [31:0]            qty_mem  [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.info_we) begin
      info_mem[wr_addr_i] <= wr_i.info;
    end
    if (wr_i.qty_we) begin
      qty_mem[wr_addr_i] <= wr_i.qty;
    end
    if (rd_en_i) begin
      rd_info_o <= info_mem[rd_addr_i];
      rd_qty_o  <= qty_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_o <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_o <= valid_q[rd_addr_i];
      end
      if (wr_i.set_valid) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (wr_i.clr_valid) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
    end
  end

endmodule

>>> tb/sv/price_time_order_matcher_test.sv
module price_time_order_matcher_test;

  localparam int SLOTS      = 64;
  localparam int MAX_OUT    = 64;
  localparam int STALL_MAX  = 40000;
  localparam int DRAIN_WAIT = 200;
  localparam int RAND_ITEMS = 15;

  localparam logic ADD    = ptom_pkg::CMD_ADD;
  localparam logic CANCEL = ptom_pkg::CMD_CANCEL;
  localparam logic BUY    = ptom_pkg::SIDE_BUY;
  localparam logic SELL   = ptom_pkg::SIDE_SELL;

  // One item as it crosses the input channel.
  typedef struct {
    logic        cmd;
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [47:0] stamp;
  } order_item_t;

  // A directed row: the item, and where it is obvious, the kind of its
  // closing result.
  typedef struct {
    order_item_t     item;
    logic            has_kind;
    ptom_pkg::kind_e kind;
  } directed_row_t;

  typedef struct {
    ptom_pkg::kind_e kind;
    logic [31:0]     bid_id;
    logic [31:0]     ask_id;
    logic [31:0]     trade_qty;
    logic [31:0]     trade_px;
    logic            full;
    logic [31:0]     subject;
    logic [31:0]     remaining;
    logic            last;
  } book_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = ptom_pkg::CMD_ADD;
  logic [31:0] order_id_i = '0;
  logic        side_i = ptom_pkg::SIDE_BUY;
  logic [31:0] price_i = '0;
  logic [31:0] quantity_i = '0;
  logic [47:0] timestamp_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  kind_o;
  logic [31:0] bid_order_id_o;
  logic [31:0] ask_order_id_o;
  logic [31:0] trade_quantity_o;
  logic [31:0] trade_price_o;
  logic        full_fill_o;
  logic [31:0] subject_id_o;
  logic [31:0] remaining_quantity_o;
  logic        last_o;

  price_time_order_matcher #(.ORDER_SLOTS(SLOTS)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .order_id_i, .side_i,
    .price_i, .quantity_i, .timestamp_i, .out_valid_o, .out_ready_i, .kind_o,
    .bid_order_id_o, .ask_order_id_o, .trade_quantity_o, .trade_price_o,
    .full_fill_o, .subject_id_o, .remaining_quantity_o, .last_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The testbench's own copy of the order book.
  logic        book_valid [SLOTS];
  logic [31:0] book_id    [SLOTS];
  logic        book_side  [SLOTS];
  logic [31:0] book_price [SLOTS];
  logic [31:0] book_qty   [SLOTS];
  logic [47:0] book_stamp [SLOTS];
  logic [31:0] book_arr   [SLOTS];
  logic [31:0] arrivals;

  book_result_t  expected_results[$];
  directed_row_t rows[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int trades_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  function automatic void expect_result(book_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic book_result_t take_expected();
    book_result_t r;
    r = expected_results[0];
    expected_results.delete(0);
    return r;
  endfunction

  function automatic int resting_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (book_valid[i]) n++;
    return n;
  endfunction

  // Best resting order of one side: highest bid or lowest ask, oldest first
  // within a price, lower slot on a tie of age. Returns -1 for an empty side.
  function automatic int best_order(logic side);
    int best;
    logic better;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!book_valid[i] || book_side[i] != side) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (book_price[i] != book_price[best])
        better = (side == BUY) ? book_price[i] > book_price[best]
                               : book_price[i] < book_price[best];
      else
        better = 32'(arrivals - book_arr[i]) > 32'(arrivals - book_arr[best]);
      if (better) best = i;
    end
    return best;
  endfunction

  function automatic book_result_t closing(ptom_pkg::kind_e kind, logic [31:0] subject,
                                           logic [31:0] remaining);
    book_result_t r;
    r = '{kind: kind, bid_id: '0, ask_id: '0, trade_qty: '0, trade_px: '0,
          full: 1'b0, subject: subject, remaining: remaining, last: 1'b1};
    return r;
  endfunction

  // Applies one item to the book and queues the results it should produce.
  function automatic void match_item(order_item_t it);
    int found, free_slot, s, b, a, n;
    logic [31:0] tq, bq, aq;
    book_result_t r;
    found = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (book_valid[i]) begin
        if (found < 0 && book_id[i] == it.id) found = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (it.cmd == CANCEL) begin
      if (found < 0) begin
        expect_result(closing(ptom_pkg::KIND_NOT_FOUND, it.id, '0));
      end else begin
        book_valid[found] = 1'b0;
        expect_result(closing(ptom_pkg::KIND_CANCELLED, it.id, '0));
      end
      return;
    end
    if (it.qty == 0) begin
      expect_result(closing(ptom_pkg::KIND_ZERO_QTY, it.id, '0));
      return;
    end
    if (found >= 0 || free_slot < 0) begin
      expect_result(closing(ptom_pkg::KIND_REJECT, it.id, '0));
      return;
    end
    s = free_slot;
    book_valid[s] = 1'b1;
    book_id[s]    = it.id;
    book_side[s]  = it.side;
    book_price[s] = it.price;
    book_qty[s]   = it.qty;
    book_stamp[s] = it.stamp;
    book_arr[s]   = arrivals;
    arrivals++;
    n = 0;
    // Trade while the book is crossed, leaving room for the closing result.
    while (n < MAX_OUT - 1) begin
      b = best_order(BUY);
      a = best_order(SELL);
      if (b < 0 || a < 0 || book_price[b] < book_price[a]) break;
      bq = book_qty[b];
      aq = book_qty[a];
      tq = (bq < aq) ? bq : aq;
      r.kind      = ptom_pkg::KIND_TRADE;
      r.bid_id    = book_id[b];
      r.ask_id    = book_id[a];
      r.trade_qty = tq;
      // The earlier order sets the price; a tie goes to the ask.
      r.trade_px  = (book_stamp[b] < book_stamp[a]) ? book_price[b] : book_price[a];
      r.full      = (bq == tq) && (aq == tq);
      r.subject   = '0;
      r.remaining = '0;
      r.last      = 1'b0;
      expect_result(r);
      n++;
      book_qty[b] = bq - tq;
      book_qty[a] = aq - tq;
      if (book_qty[b] == 0) book_valid[b] = 1'b0;
      if (book_qty[a] == 0) book_valid[a] = 1'b0;
    end
    expect_result(closing(ptom_pkg::KIND_ADDED, it.id,
                          book_valid[s] ? book_qty[s] : 32'd0));
  endfunction

  // Offers one item, idling first at random, and waits for its acceptance.
  task automatic offer_item(order_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_i       <= it.cmd;
    order_id_i  <= it.id;
    side_i      <= it.side;
    price_i     <= it.price;
    quantity_i  <= it.qty;
    timestamp_i <= it.stamp;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    match_item(it);
    items_sent++;
  endtask

  function automatic order_item_t make_item(logic cmd, logic [31:0] id, logic side,
                                            logic [31:0] price, logic [31:0] qty,
                                            logic [47:0] stamp);
    order_item_t it;
    it = '{cmd: cmd, id: id, side: side, price: price, qty: qty, stamp: stamp};
    return it;
  endfunction

  function automatic void add_row(order_item_t it, logic has_kind, ptom_pkg::kind_e kind);
    directed_row_t row;
    row.item     = it;
    row.has_kind = has_kind;
    row.kind     = kind;
    rows.insert(rows.size(), row);
  endfunction

  // Random item: ids from a small pool so that duplicates and cancels hit,
  // prices near one level so that the book crosses often.
  function automatic order_item_t random_item();
    order_item_t it;
    it.cmd   = ($urandom_range(3) == 0) ? CANCEL : ADD;
    it.id    = ($urandom_range(7) == 0) ? 32'($urandom) : 32'($urandom_range(1, 24));
    it.side  = $urandom_range(1) ? SELL : BUY;
    it.price = ($urandom_range(15) == 0) ? 32'($urandom) : 32'($urandom_range(95, 105));
    case ($urandom_range(9))
      0: it.qty = '0;
      1: it.qty = 32'($urandom);
      default: it.qty = 32'($urandom_range(1, 20));
    endcase
    it.stamp = {16'($urandom), 32'($urandom)};
    return it;
  endfunction

  task automatic report_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      errors++;
    end
  endtask

  // Receiver: random back-pressure, result checking and the watchdog.
  always @(posedge clk_i) begin
    book_result_t want;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (kind_o == ptom_pkg::KIND_TRADE) trades_seen++;
        if (expected_results.size() == 0) begin
          $error("result of kind %0d arrived with none expected", kind_o);
          errors++;
        end else begin
          want = take_expected();
          report_field("kind", 32'(want.kind), 32'(kind_o));
          report_field("bid_order_id", want.bid_id, bid_order_id_o);
          report_field("ask_order_id", want.ask_id, ask_order_id_o);
          report_field("trade_quantity", want.trade_qty, trade_quantity_o);
          report_field("trade_price", want.trade_px, trade_price_o);
          report_field("full_fill", 32'(want.full), 32'(full_fill_o));
          report_field("subject_id", want.subject, subject_id_o);
          report_field("remaining_quantity", want.remaining, remaining_quantity_o);
          report_field("last", 32'(want.last), 32'(last_o));
        end
      end
    end
  end

  initial begin
    order_item_t it;
    int n;
    for (int i = 0; i < SLOTS; i++) book_valid[i] = 1'b0;
    arrivals = '0;

    // Empty book, zero quantity, duplicates, trade price by timestamp with
    // a tie going to the ask, extreme ids, prices and quantities, cancels
    // that hit and miss, and oldest-first within one price level.
    add_row(make_item(CANCEL, 32'd5, BUY, 32'd0, 32'd0, 48'd0), 1'b1,
            ptom_pkg::KIND_NOT_FOUND);
    add_row(make_item(ADD, 32'd9, BUY, 32'd100, 32'd0, 48'd0), 1'b1,
            ptom_pkg::KIND_ZERO_QTY);
    add_row(make_item(ADD, 32'd1, BUY, 32'd100, 32'd10, 48'd5), 1'b1,
            ptom_pkg::KIND_ADDED);
    add_row(make_item(ADD, 32'd1, SELL, 32'd90, 32'd3, 48'd5), 1'b1,
            ptom_pkg::KIND_REJECT);
    add_row(make_item(ADD, 32'd2, SELL, '1, '1, '1), 1'b1, ptom_pkg::KIND_ADDED);
    add_row(make_item(ADD, 32'd3, SELL, 32'd90, 32'd4, 48'd5), 1'b0,
            ptom_pkg::KIND_ADDED);
    add_row(make_item(ADD, 32'd4, SELL, 32'd100, 32'd6, 48'd1), 1'b0,
            ptom_pkg::KIND_ADDED);
    add_row(make_item(ADD, 32'd0, BUY, '1, 32'd1, 48'd0), 1'b0, ptom_pkg::KIND_ADDED);
    add_row(make_item(CANCEL, 32'd2, BUY, 32'd0, 32'd0, 48'd0), 1'b1,
            ptom_pkg::KIND_CANCELLED);
    add_row(make_item(CANCEL, '1, SELL, '1, '1, '1), 1'b1, ptom_pkg::KIND_NOT_FOUND);
    add_row(make_item(ADD, '1, BUY, 32'd0, 32'h8000_0000, 48'h123), 1'b0,
            ptom_pkg::KIND_ADDED);
    add_row(make_item(ADD, 32'd10, BUY, 32'd50, 32'd3, 48'd7), 1'b0,
            ptom_pkg::KIND_ADDED);
    add_row(make_item(ADD, 32'd11, BUY, 32'd50, 32'd3, 48'd8), 1'b0,
            ptom_pkg::KIND_ADDED);
    add_row(make_item(ADD, 32'd12, SELL, 32'd50, 32'd5, 48'd9), 1'b0,
            ptom_pkg::KIND_ADDED);
    add_row(make_item(CANCEL, 32'd11, BUY, 32'd0, 32'd0, 48'd0), 1'b1,
            ptom_pkg::KIND_CANCELLED);
    add_row(make_item(CANCEL, 32'd11, BUY, 32'd0, 32'd0, 48'd0), 1'b1,
            ptom_pkg::KIND_NOT_FOUND);
    add_row(make_item(CANCEL, '1, BUY, 32'd0, 32'd0, 48'd0), 1'b1,
            ptom_pkg::KIND_CANCELLED);
    add_row(make_item(ADD, '1, SELL, 32'd7, 32'd0, 48'd0), 1'b1,
            ptom_pkg::KIND_ZERO_QTY);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 29;
    recv_idle_pct = 87;
    foreach (rows[i]) begin
      offer_item(rows[i].item);
      if (rows[i].has_kind && expected_results[$].kind != rows[i].kind) begin
        $error("row %0d: kind expected %0d, predicted %0d", i, rows[i].kind,
               expected_results[$].kind);
        errors++;
      end
    end

    // Fill the store with small buys, then one more must be turned away.
    // A sweeping sell then crosses every buy and runs into the trade limit.
    send_idle_pct = 87;
    recv_idle_pct = 29;
    n = 0;
    while (resting_count() < SLOTS) begin
      offer_item(make_item(ADD, 1000 + n, BUY, 1 + n % 5, 32'd1, 48'(n)));
      n++;
    end
    offer_item(make_item(ADD, 32'd3000, BUY, 32'd3, 32'd1, 48'd0));
    if (expected_results[$].kind != ptom_pkg::KIND_REJECT) begin
      $error("store full: kind expected %0d, predicted %0d", ptom_pkg::KIND_REJECT,
             expected_results[$].kind);
      errors++;
    end
    offer_item(make_item(CANCEL, 32'd1000, BUY, 32'd0, 32'd0, 48'd0));
    offer_item(make_item(ADD, 32'd2000, SELL, 32'd0, 32'd100, 48'd500));

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i < RAND_ITEMS / 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 87;
      end else if (i < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      it = random_item();
      offer_item(it);
    end
    in_valid_i <= 1'b0;

    // The watchdog bounds this wait.
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results including %0d trades.",
             items_sent, results_seen, trades_seen);
    $display("Book extremes, a full store and the per-item trade limit were driven.");
    if (errors == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
src/ptom_pkg.sv
src/ptom_store.sv
src/price_time_order_matcher.sv
tb/sv/price_time_order_matcher_test.sv
